/* rtl/fpa_pkg.sv */
// Package with the request and result types and command codes of the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_GT  = 4'd4;
  localparam logic [3:0] CMD_LT  = 4'd5;
  localparam logic [3:0] CMD_GE  = 4'd6;
  localparam logic [3:0] CMD_LE  = 4'd7;
  localparam logic [3:0] CMD_EQ  = 4'd8;
  localparam logic [3:0] CMD_NE  = 4'd9;
  localparam logic [3:0] CMD_MIN = 4'd10;
  localparam logic [3:0] CMD_MAX = 4'd11;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIV0 = 2'd2;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } fpa_out_t;

  // Work item handed from stage to stage along the pipeline.
  typedef struct packed {
    logic [3:0]  cmd;
    logic        neg;
    logic [31:0] mb;
    logic [31:0] rem;
    logic [63:0] acc;
    logic [31:0] res;
    logic        flag;
  } fpa_work_t;

endpackage
`default_nettype wire

/* rtl/fpa_front.sv */
// Front stages: operand magnitudes, simple results, and the product or scaled dividend.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire fpa_pkg::fpa_in_t   in_req,
  output logic                    work_valid,
  output fpa_pkg::fpa_work_t      work
);

  fpa_pkg::fpa_work_t a_r, a_nxt;
  fpa_pkg::fpa_work_t b_r, b_nxt;
  logic               a_valid_r, b_valid_r;

  // First stage: magnitudes, sign and the results of the add, subtract, compare, min and max commands.
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    a = in_req.operand_a;
    b = in_req.operand_b;
    a_nxt      = '0;
    a_nxt.cmd  = in_req.command;
    a_nxt.neg  = a[31] ^ b[31];
    a_nxt.acc  = {32'd0, (a[31] ? 32'(-a) : 32'(a))};
    a_nxt.mb   = b[31] ? 32'(-b) : 32'(b);
    case (in_req.command)
      fpa_pkg::CMD_ADD: a_nxt.res = 32'(a + b);
      fpa_pkg::CMD_SUB: a_nxt.res = 32'(a - b);
      fpa_pkg::CMD_GT:  a_nxt.flag = (a > b);
      fpa_pkg::CMD_LT:  a_nxt.flag = (a < b);
      fpa_pkg::CMD_GE:  a_nxt.flag = (a >= b);
      fpa_pkg::CMD_LE:  a_nxt.flag = (a <= b);
      fpa_pkg::CMD_EQ:  a_nxt.flag = (a == b);
      fpa_pkg::CMD_NE:  a_nxt.flag = (a != b);
      fpa_pkg::CMD_MIN: a_nxt.res = (a < b) ? a : b;
      fpa_pkg::CMD_MAX: a_nxt.res = (a > b) ? a : b;
      default: a_nxt.res = '0;
    endcase
  end

  // Second stage: full product for multiply, scaled dividend otherwise.
  always_comb begin
    b_nxt     = a_r;
    b_nxt.rem = '0;
    if (a_r.cmd == fpa_pkg::CMD_MUL) begin
      b_nxt.acc = 64'(a_r.acc[31:0]) * 64'(a_r.mb);
    end else begin
      b_nxt.acc = a_r.acc << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign work_valid = b_valid_r;
  assign work       = b_r;

endmodule
`default_nettype wire

/* rtl/fpa_div_cell.sv */
// One restoring-divide cell: develops one quotient bit and passes the item on.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell #(
  parameter int NUM_BITS = 40
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                prev_valid,
  input  wire fpa_pkg::fpa_work_t  prev,
  output logic                     cell_valid,
  output fpa_pkg::fpa_work_t       next_work
);

  fpa_pkg::fpa_work_t cell_r, cell_nxt;
  logic               valid_r;

  // Bring the next dividend bit into the partial remainder and try the divisor.
  always_comb begin
    logic [32:0] trial;
    logic        qbit;
    trial    = {prev.rem, prev.acc[NUM_BITS-1]};
    qbit     = (trial >= {1'b0, prev.mb});
    cell_nxt = prev;
    if (prev.cmd == fpa_pkg::CMD_DIV) begin
      cell_nxt.rem = qbit ? 32'(trial - {1'b0, prev.mb}) : trial[31:0];
      cell_nxt.acc = {prev.acc[62:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign next_work  = cell_r;

endmodule
`default_nettype wire

/* rtl/fpa_back.sv */
// Back stage: rounding, saturation, status and the output register.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                work_valid,
  input  wire fpa_pkg::fpa_work_t  work,
  output logic                     out_valid,
  output fpa_pkg::fpa_out_t        out_rsp
);

  localparam int NUM_BITS = 32 + FRAC_BITS;
  localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] QMASK = (64'd1 << NUM_BITS) - 64'd1;

  fpa_pkg::fpa_out_t rsp_r, rsp_nxt;
  logic              valid_r;

  // Round the multiply or divide magnitude half away from zero, apply sign and clamp.
  always_comb begin
    logic [63:0] q;
    logic        up;
    logic        sat;
    logic [31:0] val;
    up  = ({work.rem, 1'b0} >= {1'b0, work.mb});
    if (work.cmd == fpa_pkg::CMD_MUL) begin
      q = (work.acc + HALF) >> FRAC_BITS;
    end else begin
      q = (work.acc & QMASK) + 64'(up);
    end
    sat = 1'b0;
    if (work.neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        val = 32'h8000_0000;
      end else begin
        val = 32'(-q);
      end
    end else begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        val = 32'h7FFF_FFFF;
      end else begin
        val = q[31:0];
      end
    end
    rsp_nxt              = '0;
    rsp_nxt.compare_true = work.flag;
    case (work.cmd)
      fpa_pkg::CMD_MUL: begin
        rsp_nxt.result_value = val;
        rsp_nxt.status       = sat ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
      end
      fpa_pkg::CMD_DIV: begin
        if (work.mb == 32'd0) begin
          rsp_nxt.status = fpa_pkg::STAT_DIV0;
        end else begin
          rsp_nxt.result_value = val;
          rsp_nxt.status       = sat ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
        end
      end
      default: rsp_nxt.result_value = work.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule
`default_nettype wire

/* rtl/fixed_point_alu.sv */
// Top level of the pipelined signed fixed-point ALU.
// A request is accepted in every cycle in which the result side is not stalled, and its
// result passes through two front stages (magnitudes, then the 32 x 32 product or the
// scaled dividend), a divide chain of 32 + FRAC_BITS cells, one quotient bit per cell,
// and the output register. All commands take the same path, so results leave in request
// order. A stall on the result side freezes the whole pipeline and raises in_stall.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpa_pkg::fpa_in_t   in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpa_pkg::fpa_out_t       out_rsp
);

  localparam int NUM_BITS = 32 + FRAC_BITS;

  logic               en;
  logic               chain_valid [NUM_BITS+1];
  fpa_pkg::fpa_work_t chain       [NUM_BITS+1];

  // The pipeline advances unless a finished result is being held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_req     (in_req),
    .work_valid (chain_valid[0]),
    .work       (chain[0])
  );

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
    fpa_div_cell #(.NUM_BITS(NUM_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .prev_valid (chain_valid[i]),
      .prev       (chain[i]),
      .cell_valid (chain_valid[i+1]),
      .next_work  (chain[i+1])
    );
  end

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .work_valid (chain_valid[NUM_BITS]),
    .work       (chain[NUM_BITS]),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp)
  );

endmodule
`default_nettype wire

/* rtl/fpa_checker.sv */
// Port-level checker for the fixed-point ALU and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire fpa_pkg::fpa_in_t  in_req,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire fpa_pkg::fpa_out_t out_rsp
);

  // No result comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled request stays presented and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_req)))
    else $error("stalled request changed");

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
    else $error("held result changed");

  // A true compare carries a zero value and ok status.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.compare_true) |->
      (out_rsp.result_value == 32'sd0 && out_rsp.status == fpa_pkg::STAT_OK))
    else $error("compare result carries value or status");

  // Divide by zero gives a zero value; status code three never appears.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status != 2'd3 &&
      (out_rsp.status != fpa_pkg::STAT_DIV0 || out_rsp.result_value == 32'sd0)))
    else $error("bad status or divide-by-zero value");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
`default_nettype wire

/* verif/fixed_point_alu_checker.sv */
// Checker that predicts and compares every result of the fixed-point ALU.
`timescale 1ns / 1ps
module fixed_point_alu_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  fpa_pkg::fpa_in_t  in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  fpa_pkg::fpa_out_t out_rsp,
  output int                fail_count,
  output int                pending
);

  fpa_pkg::fpa_out_t expected_rsps[$];

  // Clamp a signed magnitude into 32 bits and note whether it clipped.
  function automatic void clamp_word(input logic [63:0] mag, input logic neg,
                                     output logic [31:0] word, output logic clipped);
    clipped = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        clipped = 1'b1;
        word = 32'h8000_0000;
      end else begin
        word = 32'(-mag);
      end
    end else if (mag > 64'h7FFF_FFFF) begin
      clipped = 1'b1;
      word = 32'h7FFF_FFFF;
    end else begin
      word = mag[31:0];
    end
  endfunction

  // Compute the result the ALU must give for one request.
  function automatic fpa_pkg::fpa_out_t alu_result(input fpa_pkg::fpa_in_t req);
    fpa_pkg::fpa_out_t r;
    logic signed [31:0] a, b;
    logic [63:0] ma, mb, prod, num, quo, rem;
    logic neg, clipped;
    a = req.operand_a;
    b = req.operand_b;
    r = '0;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-64'(a)) : 64'(a);
    mb = (b < 0) ? 64'(-64'(b)) : 64'(b);
    case (req.command)
      fpa_pkg::CMD_ADD: r.result_value = a + b;
      fpa_pkg::CMD_SUB: r.result_value = a - b;
      fpa_pkg::CMD_MUL: begin
        prod = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        clamp_word(prod, neg, r.result_value, clipped);
        r.status = clipped ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
      end
      fpa_pkg::CMD_DIV: begin
        if (mb == 0) begin
          r.status = fpa_pkg::STAT_DIV0;
        end else begin
          num = ma << FRAC_BITS;
          quo = num / mb;
          rem = num % mb;
          if (2 * rem >= mb) quo = quo + 1;
          clamp_word(quo, neg, r.result_value, clipped);
          r.status = clipped ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
        end
      end
      fpa_pkg::CMD_GT:  r.compare_true = a > b;
      fpa_pkg::CMD_LT:  r.compare_true = a < b;
      fpa_pkg::CMD_GE:  r.compare_true = a >= b;
      fpa_pkg::CMD_LE:  r.compare_true = a <= b;
      fpa_pkg::CMD_EQ:  r.compare_true = a == b;
      fpa_pkg::CMD_NE:  r.compare_true = a != b;
      fpa_pkg::CMD_MIN: r.result_value = (a < b) ? a : b;
      fpa_pkg::CMD_MAX: r.result_value = (a > b) ? a : b;
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_rsps.size();

  // Queue a prediction per accepted request; compare each accepted result.
  always @(posedge clk) begin
    fpa_pkg::fpa_out_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_rsps.push_back(alu_result(in_req));
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_rsp);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (want !== out_rsp) begin
            if (fail_count < 10)
              $display("mismatch: expected val %h cmp %b st %0d, got val %h cmp %b st %0d",
                       want.result_value, want.compare_true, want.status,
                       out_rsp.result_value, out_rsp.compare_true, out_rsp.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/tb_fixed_point_alu.sv */
// Testbench top for the fixed-point ALU: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_fixed_point_alu;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY = FRAC_BITS + 35;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  fpa_pkg::fpa_in_t in_req;
  fpa_pkg::fpa_out_t out_rsp;
  int fail_count, pending, cycles;

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_req, .out_valid, .out_stall, .out_rsp
  );

  fixed_point_alu_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_req, .out_valid, .out_stall, .out_rsp,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_fixed_point_alu: FAIL");
        $finish;
      end
    end
  end

  // Result-side stall: a random hold-off per result, sometimes none at all.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_stall) begin
        if (hold == 0) out_stall <= 1'b0;
        else hold--;
      end else if (out_valid) begin
        hold = (cycles % 3000 < 600) ? 0 : $urandom_range(0, 6);
        if (hold != 0) begin
          out_stall <= 1'b1;
          hold--;
        end
      end
    end
  end

  // Interesting operand values for the directed part.
  function automatic logic [31:0] edge_value(input int unsigned k);
    case (k % 8)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0100;
      4: return 32'hFFFF_FF00;
      5: return 32'h0000_0080;
      6: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random operand: full range, small values, an edge value, or a value within 21 signed bits.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2048)) - 1024);
      2: return edge_value($urandom);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom & 32'h000F_FFFF | ($urandom_range(0, 1) ? 32'hFFF0_0000 : 0);
    endcase
  endfunction

  // Present one request after the given gap and hold it until accepted.
  // Valid stays high after acceptance so back-to-back requests need no second drive.
  task automatic send_request(input logic [3:0] cmd, input logic [31:0] a,
                              input logic [31:0] b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= '{command: cmd, operand_a: a, operand_b: b};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [3:0] cmd;
    int gap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command, operand extremes, divide by zero, unused codes.
    for (int k = 0; k < 24; k++) begin
      cmd = (k < 16) ? 4'(k) : 4'(k % 4);
      send_request(cmd, edge_value(k), edge_value(k * 3 + 1), 0);
    end
    send_request(fpa_pkg::CMD_DIV, 32'h0000_1234, 32'h0, 0);

    // Random requests with random gaps, a stretch without gaps now and then.
    for (int n = 0; n < 1500; n++) begin
      cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      gap = (n % 300 < 60) ? 0 : $urandom_range(0, 6);
      send_request(cmd, rand_operand(), ($urandom_range(0, 30) == 0) ? 32'h0 : rand_operand(),
                   gap);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("tb_fixed_point_alu: PASS");
    else $display("tb_fixed_point_alu: FAIL");
    $finish;
  end
endmodule
